// File: src/ehp_pkg.sv
// ----------------------------------------------------------------------------
// ehp_pkg
// Shared types and constants for the Ethernet / IPv4 / layer-4 header parser.
// ----------------------------------------------------------------------------
package ehp_pkg;

  // Default width of the frame byte counter
  localparam int COUNT_BITS_DEF = 16;

  // Depth of the record queue between the front and back parts
  localparam int QUEUE_DEPTH = 2;

  // Header layout, as byte offsets from the start of the frame
  localparam int OFF_ETYPE_HI  = 12;
  localparam int OFF_ETYPE_LO  = 13;
  localparam int OFF_IHL       = 14;
  localparam int OFF_PROTO     = 23;
  localparam int OFF_SRC_FIRST = 26;
  localparam int OFF_SRC_LAST  = 29;
  localparam int OFF_DST_FIRST = 30;
  localparam int OFF_DST_LAST  = 33;
  localparam int ETH_HDR_BYTES = 14;
  localparam int L4_WINDOW     = 8;
  localparam int MIN_FRAME     = 34;
  localparam int MIN_IHL_BYTES = 20;
  localparam int L4_PORT_BYTES = 4;
  localparam int L4_ICMP_BYTES = 8;

  // Field codes
  localparam logic [15:0] ETHERTYPE_IPV4    = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP        = 8'd1;
  localparam logic [7:0]  PROTO_TCP         = 8'd6;
  localparam logic [7:0]  PROTO_UDP         = 8'd17;
  localparam logic [7:0]  ICMP_ECHO_REQUEST = 8'd8;

  // Protocol code carried with each record
  typedef enum logic [1:0] {
    PCODE_OTHER = 2'd0,
    PCODE_TCP   = 2'd1,
    PCODE_UDP   = 2'd2,
    PCODE_ICMP  = 2'd3
  } pcode_t;

  // Port payload widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 160;

  // Frame summary handed from the front part to the back part
  typedef struct packed {
    logic [15:0]     frame_length;
    pcode_t          pcode;
    logic [31:0]     src_addr;
    logic [31:0]     dst_addr;
    logic [7:0][7:0] l4_bytes;
  } ehp_rec_t;

endpackage

// File: src/ehp_front.sv
// ----------------------------------------------------------------------------
// ehp_front
// Counts frame bytes, captures header fields and layer-4 bytes, and emits a
// frame summary on the last byte of a frame that qualifies as IPv4.
// ----------------------------------------------------------------------------
module ehp_front #(
  parameter int COUNT_BITS = ehp_pkg::COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             byte_acc,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  input  logic [15:0]      wire_length,
  output logic             rec_push,
  output ehp_pkg::ehp_rec_t rec
);
  import ehp_pkg::*;

  localparam logic [COUNT_BITS-1:0] OFF_MAX = '1;

  logic [COUNT_BITS-1:0] off_r, off_nxt, off_upd, captured;
  logic [15:0]           etype_r, etype_nxt, etype_upd;
  logic [5:0]            hb_r, hb_nxt, hb_upd;
  logic [7:0]            proto_r, proto_nxt, proto_upd;
  logic [31:0]           src_r, src_nxt, src_upd;
  logic [31:0]           dst_r, dst_nxt, dst_upd;
  logic [7:0][7:0]       l4_r, l4_nxt, l4_upd;
  logic [6:0]            l4_lo, l4_hi, need_ports, need_icmp;
  logic [2:0]            l4_idx;
  logic                  rec_ok;
  pcode_t                pcode;

  // Capture fields at their fixed offsets for the current item
  always_comb begin
    etype_upd = etype_r;
    hb_upd    = hb_r;
    proto_upd = proto_r;
    src_upd   = src_r;
    dst_upd   = dst_r;
    l4_upd    = l4_r;
    if (off_r == COUNT_BITS'(OFF_ETYPE_HI) || off_r == COUNT_BITS'(OFF_ETYPE_LO)) begin
      etype_upd = {etype_r[7:0], data_byte};
    end else if (off_r == COUNT_BITS'(OFF_IHL)) begin
      hb_upd = {data_byte[3:0], 2'b00};
    end else if (off_r == COUNT_BITS'(OFF_PROTO)) begin
      proto_upd = data_byte;
    end else if (off_r >= COUNT_BITS'(OFF_SRC_FIRST) && off_r <= COUNT_BITS'(OFF_SRC_LAST)) begin
      src_upd = {src_r[23:0], data_byte};
    end else if (off_r >= COUNT_BITS'(OFF_DST_FIRST) && off_r <= COUNT_BITS'(OFF_DST_LAST)) begin
      dst_upd = {dst_r[23:0], data_byte};
    end

    // Layer-4 window starts right after the IPv4 header
    l4_lo  = 7'(ETH_HDR_BYTES) + {1'b0, hb_upd};
    l4_hi  = 7'(ETH_HDR_BYTES + L4_WINDOW) + {1'b0, hb_upd};
    l4_idx = off_r[2:0] - l4_lo[2:0];
    if (off_r > COUNT_BITS'(OFF_IHL) && off_r >= COUNT_BITS'(l4_lo) &&
        off_r < COUNT_BITS'(l4_hi)) begin
      l4_upd[l4_idx] = data_byte;
    end

    // Advance the offset, holding at its maximum
    off_upd  = (off_r == OFF_MAX) ? off_r : off_r + COUNT_BITS'(1);
    captured = off_upd;
  end

  // Decide the record on the last byte
  always_comb begin
    need_ports = 7'(ETH_HDR_BYTES + L4_PORT_BYTES) + {1'b0, hb_upd};
    need_icmp  = 7'(ETH_HDR_BYTES + L4_ICMP_BYTES) + {1'b0, hb_upd};
    rec_ok = (captured >= COUNT_BITS'(MIN_FRAME)) && (etype_upd == ETHERTYPE_IPV4) &&
             (hb_upd >= 6'(MIN_IHL_BYTES));
    pcode = PCODE_OTHER;
    if (proto_upd == PROTO_TCP && captured >= COUNT_BITS'(need_ports)) begin
      pcode = PCODE_TCP;
    end else if (proto_upd == PROTO_UDP && captured >= COUNT_BITS'(need_ports)) begin
      pcode = PCODE_UDP;
    end else if (proto_upd == PROTO_ICMP && captured >= COUNT_BITS'(need_icmp)) begin
      pcode = PCODE_ICMP;
    end
    rec_push         = byte_acc && last_byte && rec_ok;
    rec.frame_length = wire_length;
    rec.pcode        = pcode;
    rec.src_addr     = src_upd;
    rec.dst_addr     = dst_upd;
    rec.l4_bytes     = l4_upd;
  end

  // Clear frame state after the last byte, hold when no item arrives
  always_comb begin
    off_nxt   = off_r;
    etype_nxt = etype_r;
    hb_nxt    = hb_r;
    proto_nxt = proto_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    l4_nxt    = l4_r;
    if (byte_acc) begin
      if (last_byte) begin
        off_nxt   = '0;
        etype_nxt = '0;
        hb_nxt    = '0;
        proto_nxt = '0;
        src_nxt   = '0;
        dst_nxt   = '0;
        l4_nxt    = '0;
      end else begin
        off_nxt   = off_upd;
        etype_nxt = etype_upd;
        hb_nxt    = hb_upd;
        proto_nxt = proto_upd;
        src_nxt   = src_upd;
        dst_nxt   = dst_upd;
        l4_nxt    = l4_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r   <= '0;
      etype_r <= '0;
      hb_r    <= '0;
      proto_r <= '0;
      src_r   <= '0;
      dst_r   <= '0;
      l4_r    <= '0;
    end else begin
      off_r   <= off_nxt;
      etype_r <= etype_nxt;
      hb_r    <= hb_nxt;
      proto_r <= proto_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
      l4_r    <= l4_nxt;
    end
  end

endmodule

// File: src/ehp_queue.sv
// ----------------------------------------------------------------------------
// ehp_queue
// Short first-in first-out queue of frame summaries between front and back.
// ----------------------------------------------------------------------------
module ehp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ehp_pkg::ehp_rec_t wr_rec,
  output logic              full,
  output logic              not_empty,
  input  logic              pop,
  output ehp_pkg::ehp_rec_t rd_rec
);
  import ehp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

  ehp_rec_t          slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rd_rec    = slot_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed summary
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_rec;
    end
  end

endmodule

// File: src/ehp_back.sv
// ----------------------------------------------------------------------------
// ehp_back
// Formats frame summaries into result items and holds them in an output
// register until the downstream side takes them.
// ----------------------------------------------------------------------------
module ehp_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                rec_valid,
  input  ehp_pkg::ehp_rec_t                   rec,
  output logic                                rec_pop,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // frame_length, source_address, dest_address, source_port, dest_port,
  // icmp_kind, icmp_ident, icmp_sequence, outbound, zero fill
  output logic [ehp_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // protocol_code
  output logic [1:0]                          out_tuser
);
  import ehp_pkg::*;

  logic                   valid_r, valid_nxt;
  logic [OUT_TDATA_W-1:0] data_r, data_nxt;
  logic [1:0]             user_r, user_nxt;
  logic [15:0]            sport, dport, ident, seq;
  logic [7:0]             kind;
  logic                   outb;

  // Pick layer-4 fields according to the protocol code
  always_comb begin
    sport = '0;
    dport = '0;
    kind  = '0;
    ident = '0;
    seq   = '0;
    outb  = 1'b0;
    case (rec.pcode)
      PCODE_TCP, PCODE_UDP: begin
        sport = {rec.l4_bytes[0], rec.l4_bytes[1]};
        dport = {rec.l4_bytes[2], rec.l4_bytes[3]};
      end
      PCODE_ICMP: begin
        kind  = rec.l4_bytes[0];
        ident = {rec.l4_bytes[4], rec.l4_bytes[5]};
        seq   = {rec.l4_bytes[6], rec.l4_bytes[7]};
        outb  = (rec.l4_bytes[0] == ICMP_ECHO_REQUEST);
      end
      default: begin
        sport = '0;
      end
    endcase
  end

  // Load the output register whenever it is empty or being drained
  assign rec_pop = rec_valid && (!valid_r || out_tready);

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    user_nxt  = user_r;
    if (rec_pop) begin
      valid_nxt = 1'b1;
      data_nxt  = {7'd0, outb, seq, ident, kind, dport, sport,
                   rec.dst_addr, rec.src_addr, rec.frame_length};
      user_nxt  = rec.pcode;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    user_r <= user_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;

endmodule

// File: src/eth_ipv4_l4_header_parser.sv
// ----------------------------------------------------------------------------
// eth_ipv4_l4_header_parser
// Parses Ethernet / IPv4 / TCP, UDP and ICMP headers from a byte stream.
// ----------------------------------------------------------------------------
// Frame bytes enter one per cycle on the input stream while in_tready is high,
// tlast on the final byte, with the wire length in the upper tdata bits of that
// byte. The front part updates the offset counter and the captured fields for
// each accepted byte, and on the last byte of a qualifying IPv4 frame pushes a
// summary into a two-entry queue. The back part formats the summary into one
// result item in an output register, so a result passes through the queue and
// the output register before it appears. Input is held off only while the queue
// is full, which happens only when results back up downstream. Frames that are
// not IPv4, are shorter than 34 bytes or have a header length below 20 give no
// result. The byte counter saturates at 2^COUNT_BITS - 1.
// ----------------------------------------------------------------------------
module eth_ipv4_l4_header_parser #(
  parameter int COUNT_BITS = ehp_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // data_byte, wire_length
  input  logic [ehp_pkg::IN_TDATA_W-1:0]  in_tdata,
  // last_byte
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // frame_length, source_address, dest_address, source_port, dest_port,
  // icmp_kind, icmp_ident, icmp_sequence, outbound, zero fill
  output logic [ehp_pkg::OUT_TDATA_W-1:0] out_tdata,
  // protocol_code
  output logic [1:0]                      out_tuser
);
  import ehp_pkg::*;

  logic     byte_acc, rec_push, q_full, q_not_empty, rec_pop;
  ehp_rec_t front_rec, back_rec;

  assign in_tready = !q_full;
  assign byte_acc  = in_tvalid && in_tready;

  // Front part: count bytes and capture fields
  ehp_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_acc    (byte_acc),
    .data_byte   (in_tdata[7:0]),
    .last_byte   (in_tlast),
    .wire_length (in_tdata[23:8]),
    .rec_push    (rec_push),
    .rec         (front_rec)
  );

  // Queue of frame summaries
  ehp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rec_push),
    .wr_rec    (front_rec),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (rec_pop),
    .rd_rec    (back_rec)
  );

  // Back part: format and hold results
  ehp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rec_valid  (q_not_empty),
    .rec        (back_rec),
    .rec_pop    (rec_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
